// ----- src/lvn_pkg.sv -----
// Shared constants, codes and types for the lattice value noise pipeline.
// No dependencies; every other source file except lvn_ram imports this package.
package lvn_pkg;

  localparam int COORD_W   = 32;
  localparam int FRAC_BITS = 16;
  localparam int IDX_W     = 8;
  localparam int ENTRIES   = 256;
  localparam int VAL_W     = 16;
  localparam int CMD_W     = 3;

  localparam logic [CMD_W-1:0] CMD_EVAL   = 3'd0;
  localparam logic [CMD_W-1:0] CMD_PERM_X = 3'd1;
  localparam logic [CMD_W-1:0] CMD_PERM_Y = 3'd2;
  localparam logic [CMD_W-1:0] CMD_PERM_Z = 3'd3;
  localparam logic [CMD_W-1:0] CMD_VALUE  = 3'd4;

  typedef logic [IDX_W-1:0]     idx_t;
  typedef logic [FRAC_BITS-1:0] frac_t;
  typedef logic [VAL_W-1:0]     val_t;

  typedef struct packed {
    logic [2:0] perm_we;
    idx_t       perm_addr;
    idx_t       perm_data;
    logic       val_we;
    idx_t       val_addr;
    val_t       val_data;
  } tbl_wr_t;

endpackage

// ----- src/lvn_ram.sv -----
// Generic RAM: one write port, two read ports with registered read data.
// Stand-alone; no package needed.
module lvn_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256,
  localparam int AW   = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr0,
  input  logic [AW-1:0]    raddr1,
  output logic [WIDTH-1:0] rdata0,
  output logic [WIDTH-1:0] rdata1
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd0_r;
  logic [WIDTH-1:0] rd1_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rd0_r <= mem[raddr0];
      rd1_r <= mem[raddr1];
    end
  end

  assign rdata0 = rd0_r;
  assign rdata1 = rd1_r;

endmodule

// ----- src/lvn_ease.sv -----
// Two-stage smoothstep s = f*f*(3-2f) for the three axes.
// Depends on lvn_pkg.
module lvn_ease (
  input  logic          clk,
  input  logic          en,
  input  lvn_pkg::frac_t f_in [3],
  output lvn_pkg::frac_t s_out [3]
);
  import lvn_pkg::*;

  localparam logic [FRAC_BITS+1:0] THREE_ONE = (FRAC_BITS+2)'(3) << FRAC_BITS;

  frac_t                      f_r   [3];
  frac_t                      t_r   [3];
  frac_t                      t_nxt [3];
  frac_t                      s_r   [3];
  frac_t                      s_nxt [3];
  logic [2*FRAC_BITS-1:0]     sq    [3];
  logic [FRAC_BITS+1:0]       k     [3];
  logic [2*FRAC_BITS+1:0]     prod  [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      sq[i]    = (2*FRAC_BITS)'(f_in[i]) * (2*FRAC_BITS)'(f_in[i]);
      t_nxt[i] = sq[i][2*FRAC_BITS-1:FRAC_BITS];
      k[i]     = THREE_ONE - {1'b0, f_r[i], 1'b0};
      prod[i]  = (2*FRAC_BITS+2)'(t_r[i]) * (2*FRAC_BITS+2)'(k[i]);
      s_nxt[i] = prod[i][2*FRAC_BITS-1:FRAC_BITS];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      f_r <= f_in;
      t_r <= t_nxt;
      s_r <= s_nxt;
    end
  end

  assign s_out = s_r;

endmodule

// ----- src/lvn_lookup.sv -----
// Permutation and value tables: corner hashing and eight corner value reads.
// Depends on lvn_pkg and lvn_ram.
module lvn_lookup (
  input  logic             clk,
  input  logic             en,
  input  lvn_pkg::tbl_wr_t wr,
  input  lvn_pkg::idx_t    lat_idx [3],
  output lvn_pkg::val_t    vals [8]
);
  import lvn_pkg::*;

  idx_t perm_rd [3][2];
  idx_t hash    [8];

  for (genvar i = 0; i < 3; i++) begin : g_perm
    lvn_ram #(.WIDTH(IDX_W), .DEPTH(ENTRIES)) u_perm (
      .clk    (clk),
      .we     (wr.perm_we[i]),
      .waddr  (wr.perm_addr),
      .wdata  (wr.perm_data),
      .re     (en),
      .raddr0 (lat_idx[i]),
      .raddr1 (lat_idx[i] + idx_t'(1)),
      .rdata0 (perm_rd[i][0]),
      .rdata1 (perm_rd[i][1])
    );
  end

  always_comb begin
    for (int n = 0; n < 8; n++) begin
      hash[n] = perm_rd[0][n/4] ^ perm_rd[1][(n/2)%2] ^ perm_rd[2][n%2];
    end
  end

  // one copy per (x,y) corner pair; its two ports cover both z corners
  for (genvar k = 0; k < 4; k++) begin : g_val
    lvn_ram #(.WIDTH(VAL_W), .DEPTH(ENTRIES)) u_val (
      .clk    (clk),
      .we     (wr.val_we),
      .waddr  (wr.val_addr),
      .wdata  (wr.val_data),
      .re     (en),
      .raddr0 (hash[2*k]),
      .raddr1 (hash[2*k+1]),
      .rdata0 (vals[2*k]),
      .rdata1 (vals[2*k+1])
    );
  end

endmodule

// ----- src/lvn_blend.sv -----
// Three-stage trilinear blend: along z, then y, then x.
// Depends on lvn_pkg.
module lvn_blend (
  input  logic           clk,
  input  logic           en,
  input  lvn_pkg::val_t  vals [8],
  input  lvn_pkg::frac_t s_in [3],
  output lvn_pkg::val_t  noise
);
  import lvn_pkg::*;

  localparam int ACC_W = VAL_W + FRAC_BITS + 1;

  function automatic val_t lerp(input val_t p, input val_t q, input frac_t s);
    logic [FRAC_BITS:0] w;
    logic [ACC_W-1:0]   acc;
    w   = {1'b1, {FRAC_BITS{1'b0}}} - {1'b0, s};
    acc = ACC_W'(p) * ACC_W'(w) + ACC_W'(q) * ACC_W'(s);
    return acc[VAL_W+FRAC_BITS-1:FRAC_BITS];
  endfunction

  val_t  row_r   [4];
  val_t  row_nxt [4];
  frac_t sy_r;
  frac_t sx_d_r;
  val_t  plane_r [2];
  frac_t sx_e_r;
  val_t  out_r;

  always_comb begin
    for (int k = 0; k < 4; k++) begin
      row_nxt[k] = lerp(vals[2*k], vals[2*k+1], s_in[2]);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      row_r      <= row_nxt;
      sy_r       <= s_in[1];
      sx_d_r     <= s_in[0];
      plane_r[0] <= lerp(row_r[0], row_r[1], sy_r);
      plane_r[1] <= lerp(row_r[2], row_r[3], sy_r);
      sx_e_r     <= sx_d_r;
      out_r      <= lerp(plane_r[0], plane_r[1], sx_e_r);
    end
  end

  assign noise = out_r;

endmodule

// ----- src/lattice_value_noise_3d_top.sv -----
// Top level of the 3-D lattice value noise pipeline.
// Depends on lvn_pkg, lvn_ease, lvn_lookup and lvn_blend.
//
//   channel | direction | handshake            | payload
//   in_     | request   | in_valid / in_ready   | cmd, coords, entry index/value
//   out_    | result    | out_valid / out_ready | noise_value
//
// One request enters per cycle while the output is not stalled; an evaluate result
// passes the input register, two RAM reads and three blend stages before it is presented.
// Loads give no result; table writes happen in pipeline order with reads.
// Reset clears stage valid bits only; table contents stay undefined.
// A stalled output freezes every stage, so nothing is lost or repeated.
module lattice_value_noise_3d_top (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [lvn_pkg::CMD_W-1:0]         in_cmd,
  input  logic signed [lvn_pkg::COORD_W-1:0] in_coord_x,
  input  logic signed [lvn_pkg::COORD_W-1:0] in_coord_y,
  input  logic signed [lvn_pkg::COORD_W-1:0] in_coord_z,
  input  logic [7:0]                        in_entry_index,
  input  logic [15:0]                       in_entry_value,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [15:0]                       out_noise_value
);
  import lvn_pkg::*;

  logic                en;
  logic                a_v_r;
  logic [CMD_W-1:0]    a_cmd_r;
  logic [COORD_W-1:0]  a_x_r;
  logic [COORD_W-1:0]  a_y_r;
  logic [COORD_W-1:0]  a_z_r;
  idx_t                a_idx_r;
  val_t                a_val_r;
  logic                b_v_r;
  logic [CMD_W-1:0]    b_cmd_r;
  idx_t                b_idx_r;
  val_t                b_val_r;
  logic                c_ev_r;
  logic                c_ev_nxt;
  logic                d_ev_r;
  logic                e_ev_r;
  logic                out_valid_r;
  tbl_wr_t             wr;
  idx_t                lat_idx [3];
  frac_t               frac [3];
  frac_t               s    [3];
  val_t                vals [8];
  val_t                noise;

  assign en       = !out_valid_r || out_ready;
  assign in_ready = en;
  assign c_ev_nxt = b_v_r && (b_cmd_r == CMD_EVAL);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_v_r       <= 1'b0;
      b_v_r       <= 1'b0;
      c_ev_r      <= 1'b0;
      d_ev_r      <= 1'b0;
      e_ev_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (en) begin
      a_v_r       <= in_valid;
      b_v_r       <= a_v_r;
      c_ev_r      <= c_ev_nxt;
      d_ev_r      <= c_ev_r;
      e_ev_r      <= d_ev_r;
      out_valid_r <= e_ev_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a_cmd_r <= in_cmd;
      a_x_r   <= in_coord_x;
      a_y_r   <= in_coord_y;
      a_z_r   <= in_coord_z;
      a_idx_r <= in_entry_index[IDX_W-1:0];
      a_val_r <= in_entry_value;
      b_cmd_r <= a_cmd_r;
      b_idx_r <= a_idx_r;
      b_val_r <= a_val_r;
    end
  end

  // split coordinates into wrapped lattice index and fraction
  assign lat_idx[0] = a_x_r[FRAC_BITS +: IDX_W];
  assign lat_idx[1] = a_y_r[FRAC_BITS +: IDX_W];
  assign lat_idx[2] = a_z_r[FRAC_BITS +: IDX_W];
  assign frac[0] = a_x_r[FRAC_BITS-1:0];
  assign frac[1] = a_y_r[FRAC_BITS-1:0];
  assign frac[2] = a_z_r[FRAC_BITS-1:0];

  // issue each table write at the stage that reads that table
  always_comb begin
    wr.perm_we[0] = en && a_v_r && (a_cmd_r == CMD_PERM_X);
    wr.perm_we[1] = en && a_v_r && (a_cmd_r == CMD_PERM_Y);
    wr.perm_we[2] = en && a_v_r && (a_cmd_r == CMD_PERM_Z);
    wr.perm_addr  = a_idx_r;
    wr.perm_data  = a_val_r[IDX_W-1:0];
    wr.val_we     = en && b_v_r && (b_cmd_r == CMD_VALUE);
    wr.val_addr   = b_idx_r;
    wr.val_data   = b_val_r;
  end

  lvn_ease u_ease (
    .clk   (clk),
    .en    (en),
    .f_in  (frac),
    .s_out (s)
  );

  lvn_lookup u_lookup (
    .clk     (clk),
    .en      (en),
    .wr      (wr),
    .lat_idx (lat_idx),
    .vals    (vals)
  );

  lvn_blend u_blend (
    .clk   (clk),
    .en    (en),
    .vals  (vals),
    .s_in  (s),
    .noise (noise)
  );

  assign out_valid       = out_valid_r;
  assign out_noise_value = noise;

  a_no_write_in_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !en |-> (wr.perm_we == 3'b000 && !wr.val_we))
    else $error("table write while pipeline stalled");

  a_one_perm_write: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0(wr.perm_we))
    else $error("more than one permutation table written");

  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    en && e_ev_r |=> out_valid)
    else $error("evaluate result dropped at output");

  a_load_no_result: assert property (@(posedge clk) disable iff (!rst_n)
    wr.val_we |=> !c_ev_r)
    else $error("value load marked as evaluate");

endmodule

// ----- tb/lvn_checker.sv -----
// Checker for the lattice value noise pipeline: watches both channels,
// predicts each noise value from its own copy of the tables and compares.
// Depends on lvn_pkg.
module lvn_checker (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  input  logic                               in_ready,
  input  logic [lvn_pkg::CMD_W-1:0]          in_cmd,
  input  logic signed [lvn_pkg::COORD_W-1:0] in_coord_x,
  input  logic signed [lvn_pkg::COORD_W-1:0] in_coord_y,
  input  logic signed [lvn_pkg::COORD_W-1:0] in_coord_z,
  input  logic [7:0]                         in_entry_index,
  input  logic [15:0]                        in_entry_value,
  input  logic                               out_valid,
  input  logic                               out_ready,
  input  logic [15:0]                        out_noise_value,
  output int                                 fail_count,
  output int                                 noise_pending
);
  timeunit 1ns;
  timeprecision 1ps;
  import lvn_pkg::*;

  idx_t perm_x [ENTRIES];
  idx_t perm_y [ENTRIES];
  idx_t perm_z [ENTRIES];
  val_t rand_val [ENTRIES];
  val_t noise_q [$];

  function automatic logic [63:0] smooth(logic [63:0] f);
    logic [63:0] t;
    t = (f * f) >> FRAC_BITS;
    return (t * ((64'd3 << FRAC_BITS) - 2 * f)) >> FRAC_BITS;
  endfunction

  function automatic logic [63:0] mix(logic [63:0] p, logic [63:0] q, logic [63:0] s);
    return (p * ((64'd1 << FRAC_BITS) - s) + q * s) >> FRAC_BITS;
  endfunction

  function automatic val_t lattice_val(idx_t ix, idx_t iy, idx_t iz);
    return rand_val[perm_x[ix] ^ perm_y[iy] ^ perm_z[iz]];
  endfunction

  function automatic val_t noise_at(logic [31:0] x, logic [31:0] y, logic [31:0] z);
    idx_t cx, cy, cz;
    logic [63:0] sx, sy, sz, r0, r1, p0, p1;
    cx = x[FRAC_BITS +: IDX_W];
    cy = y[FRAC_BITS +: IDX_W];
    cz = z[FRAC_BITS +: IDX_W];
    sx = smooth({48'd0, x[FRAC_BITS-1:0]});
    sy = smooth({48'd0, y[FRAC_BITS-1:0]});
    sz = smooth({48'd0, z[FRAC_BITS-1:0]});
    r0 = mix(lattice_val(cx, cy, cz), lattice_val(cx, cy, cz + 1'b1), sz);
    r1 = mix(lattice_val(cx, cy + 1'b1, cz), lattice_val(cx, cy + 1'b1, cz + 1'b1), sz);
    p0 = mix(r0, r1, sy);
    r0 = mix(lattice_val(cx + 1'b1, cy, cz), lattice_val(cx + 1'b1, cy, cz + 1'b1), sz);
    r1 = mix(lattice_val(cx + 1'b1, cy + 1'b1, cz),
             lattice_val(cx + 1'b1, cy + 1'b1, cz + 1'b1), sz);
    p1 = mix(r0, r1, sy);
    return val_t'(mix(p0, p1, sx));
  endfunction

  task automatic report_mismatch(string msg);
    $display("ERROR %0t: %s", $realtime, msg);
    fail_count++;
  endtask

  initial begin
    fail_count = 0;
    for (int i = 0; i < ENTRIES; i++) begin
      perm_x[i] = '0;
      perm_y[i] = '0;
      perm_z[i] = '0;
      rand_val[i] = '0;
    end
  end

  assign noise_pending = noise_q.size();

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (noise_q.size() == 0) begin
        report_mismatch($sformatf("unexpected noise_value %h", out_noise_value));
      end else begin
        val_t want;
        want = noise_q.pop_front();
        if (out_noise_value !== want)
          report_mismatch($sformatf("noise_value %h, want %h", out_noise_value, want));
      end
    end
    if (rst_n && in_valid && in_ready) begin
      case (in_cmd)
        CMD_EVAL:   noise_q.push_back(noise_at(in_coord_x, in_coord_y, in_coord_z));
        CMD_PERM_X: perm_x[in_entry_index] = in_entry_value[IDX_W-1:0];
        CMD_PERM_Y: perm_y[in_entry_index] = in_entry_value[IDX_W-1:0];
        CMD_PERM_Z: perm_z[in_entry_index] = in_entry_value[IDX_W-1:0];
        CMD_VALUE:  rand_val[in_entry_index] = in_entry_value;
        default: ;
      endcase
    end
  end
endmodule

// ----- tb/tb_lattice_value_noise_3d_top.sv -----
// Testbench top for lattice_value_noise_3d_top: fills the tables, streams
// points with random idling and gives the verdict. Depends on lvn_pkg, lvn_checker.
module tb_lattice_value_noise_3d_top;
  timeunit 1ns;
  timeprecision 1ps;
  import lvn_pkg::*;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [CMD_W-1:0] in_cmd = CMD_EVAL;
  logic signed [COORD_W-1:0] in_coord_x = '0, in_coord_y = '0, in_coord_z = '0;
  logic [7:0] in_entry_index = '0;
  logic [15:0] in_entry_value = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [15:0] out_noise_value;
  int fail_count, noise_pending;
  int send_idle = 0, recv_idle = 0;
  bit hold_off = 1'b0;
  int quiet_cycles = 0;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  lattice_value_noise_3d_top u_dut (.*);

  lvn_checker u_chk (.*);

  always @(posedge clk) begin
    if (hold_off) out_ready <= 1'b0;
    else out_ready <= ($urandom_range(99) >= recv_idle);
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles > 5000) begin
      $display("lattice_value_noise_3d_top test failed");
      $finish;
    end
  end

  task automatic send_request(logic [CMD_W-1:0] cmd, logic [31:0] x, logic [31:0] y,
                              logic [31:0] z, logic [7:0] idx, logic [15:0] val);
    while ($urandom_range(99) < send_idle) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_cmd <= cmd;
    in_coord_x <= x;
    in_coord_y <= y;
    in_coord_z <= z;
    in_entry_index <= idx;
    in_entry_value <= val;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  function automatic logic [31:0] rand_coord();
    case ($urandom_range(3))
      0: return $urandom();
      1: return {{16{1'b1}}, 16'(($urandom_range(1) != 0) ? 16'hFFFF : 16'h0000)}
                ^ {16'(0), 16'($urandom())};
      2: return {$urandom_range(1) ? 16'h8000 : 16'h7FFF, 16'($urandom())};
      default: return {16'($urandom_range(3)), 16'($urandom())};
    endcase
  endfunction

  task automatic eval_point();
    send_request(CMD_EVAL, rand_coord(), rand_coord(), rand_coord(), '0, '0);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (noise_pending != 0) @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  initial begin
    int c;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    for (int i = 0; i < ENTRIES; i++) begin
      send_request(CMD_PERM_X, $urandom(), 0, 0, 8'(i), 16'($urandom()));
      send_request(CMD_PERM_Y, $urandom(), 0, 0, 8'(i), 16'($urandom()));
      send_request(CMD_PERM_Z, $urandom(), 0, 0, 8'(i), 16'($urandom()));
      send_request(CMD_VALUE, $urandom(), 0, 0, 8'(i), (i == 0) ? 16'hFFFF : (i == 1) ? 16'h0
                   : 16'($urandom()));
    end
    send_request(CMD_EVAL, 32'h0, 32'h0, 32'h0, '0, '0);
    send_request(CMD_EVAL, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, '0, '0);
    send_request(CMD_EVAL, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, '0, '0);
    send_request(CMD_EVAL, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_FFFF, '0, '0);
    send_request(CMD_EVAL, 32'h00FF_8000, 32'hFF00_0001, 32'h0100_7FFF, '0, '0);
    send_request(CMD_EVAL, 32'hFFFF_0000, 32'h0001_0000, 32'hFFFE_C000, '0, '0);
    for (int k = 5; k <= 7; k++)
      send_request(3'(k), 32'h1234_5678, 32'h9ABC_DEF0, 32'hFFFF_FFFF, 8'hFF, 16'hFFFF);
    send_request(CMD_PERM_X, 0, 0, 0, 8'hFF, 16'hFFFF);
    send_request(CMD_VALUE, 0, 0, 0, 8'hFF, 16'hFFFF);
    send_request(CMD_EVAL, 32'h00FF_FFFF, 32'hFFFF_0000, 32'h0000_0001, '0, '0);
    wait_drained();

    for (int phase = 0; phase < 3; phase++) begin
      send_idle = (phase == 0) ? 21 : (phase == 1) ? 71 : 0;
      recv_idle = (phase == 0) ? 71 : (phase == 1) ? 21 : 0;
      for (int n = 0; n < 300; n++) begin
        if (phase == 2 && n == 100) begin
          hold_off = 1'b1;
          fork
            begin
              repeat (300) @(posedge clk);
              hold_off = 1'b0;
            end
          join_none
        end
        if (n == 150) wait_drained();
        c = $urandom_range(19);
        if (c < 14) eval_point();
        else if (c < 18)
          send_request(3'($urandom_range(4, 1)), $urandom(), $urandom(), $urandom(),
                       8'($urandom()), 16'($urandom()));
        else send_request(3'($urandom_range(7, 5)), $urandom(), $urandom(), $urandom(),
                          8'($urandom()), 16'($urandom()));
      end
    end
    wait_drained();
    repeat (20) @(posedge clk);
    if (fail_count == 0) $display("lattice_value_noise_3d_top test passed");
    else $display("lattice_value_noise_3d_top test failed");
    $finish;
  end
endmodule

// ----- sim.f -----
src/lvn_pkg.sv
src/lvn_ram.sv
src/lvn_ease.sv
src/lvn_lookup.sv
src/lvn_blend.sv
src/lattice_value_noise_3d_top.sv
tb/lvn_checker.sv
tb/tb_lattice_value_noise_3d_top.sv
